// ===== rtl/dlex_pkg.sv =====
// Shared types, token codes, character constants and keyword tables for the Datalog lexer.
package dlex_pkg;

    localparam int LINE_BITS_DEF     = 16;
    localparam int POSITION_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int KIND_W            = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_COMMA     = 5'd0,
        KIND_PERIOD    = 5'd1,
        KIND_QMARK     = 5'd2,
        KIND_LPAREN    = 5'd3,
        KIND_RPAREN    = 5'd4,
        KIND_COLON     = 5'd5,
        KIND_COLONDASH = 5'd6,
        KIND_MUL       = 5'd7,
        KIND_ADD       = 5'd8,
        KIND_SCHEMES   = 5'd9,
        KIND_FACTS     = 5'd10,
        KIND_RULES     = 5'd11,
        KIND_QUERIES   = 5'd12,
        KIND_ID        = 5'd13,
        KIND_STRING    = 5'd14,
        KIND_COMMENT   = 5'd15,
        KIND_UNDEF     = 5'd16,
        KIND_EOF       = 5'd17
    } tok_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ID      = 4'd1,
        PH_HASH    = 4'd2,
        PH_LC      = 4'd3,
        PH_BLK     = 4'd4,
        PH_BLK_BAR = 4'd5,
        PH_STR     = 4'd6,
        PH_STR_Q   = 4'd7,
        PH_COLON   = 4'd8
    } phase_t;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Keyword spellings, first character at index 0, padded with zero bytes.
    localparam logic [0:3][0:7][7:0] KW_TEXT = '{
        {"Schemes", 8'h00},
        {"Facts", 24'h000000},
        {"Rules", 24'h000000},
        {"Queries", 8'h00}
    };
    localparam logic [0:3][2:0] KW_LEN = '{3'd7, 3'd5, 3'd5, 3'd7};

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ===== rtl/dlex_core.sv =====
// Lexer state registers and the single-pass next-state and token logic.
module dlex_core import dlex_pkg::*; #(
    parameter int LINE_BITS     = LINE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int TOK_W         = KIND_W + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic             mode,
    input  logic [7:0]       in_byte,
    output logic [1:0]       res_cnt,
    output logic [TOK_W-1:0] res0,
    output logic [TOK_W-1:0] res1
);

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    phase_t                   phase_reg, phase_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [LINE_BITS-1:0]     tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tok_pos_reg, tok_pos_next;
    logic [LENGTH_BITS-1:0]   tok_len_reg, tok_len_next;
    logic [3:0]               cand_reg, cand_next;

    logic [LINE_BITS-1:0]   line_inc;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [3:0]             cand_upd;
    logic [3:0]             cand_first;
    tok_kind_t              id_kind;
    logic                   pend_v;
    tok_kind_t              pend_kind;
    logic [LENGTH_BITS-1:0] pend_len;
    logic                   idle_v;
    tok_kind_t              idle_kind;
    logic                   done;
    logic [TOK_W-1:0]       pend_tok;
    logic [TOK_W-1:0]       second_tok;
    logic                   second_v;

    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
    assign len_inc  = (tok_len_reg == LEN_MAX) ? tok_len_reg : tok_len_reg + LEN_ONE;

    always_comb begin
        cand_upd   = '0;
        cand_first = '0;
        id_kind    = KIND_ID;
        for (int k = 3; k >= 0; k--) begin
            cand_upd[k] = cand_reg[k]
                && (tok_len_reg < LENGTH_BITS'(KW_LEN[2'(k)]))
                && (KW_TEXT[2'(k)][tok_len_reg[2:0]] == in_byte);
            cand_first[k] = (KW_TEXT[2'(k)][0] == in_byte);
            if (cand_reg[k] && tok_len_reg == LENGTH_BITS'(KW_LEN[2'(k)])) begin
                id_kind = tok_kind_t'(KIND_W'(KIND_SCHEMES) + KIND_W'(k));
            end
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        line_next     = line_reg;
        tok_line_next = tok_line_reg;
        pos_next      = pos_reg;
        tok_pos_next  = tok_pos_reg;
        tok_len_next  = tok_len_reg;
        cand_next     = cand_reg;
        pend_v        = 1'b0;
        pend_kind     = KIND_ID;
        pend_len      = tok_len_reg;
        idle_v        = 1'b0;
        idle_kind     = KIND_UNDEF;
        done          = 1'b0;
        if (fire && mode) begin
            pend_v = (phase_reg != PH_IDLE);
            unique case (phase_reg)
                PH_ID:                      pend_kind = id_kind;
                PH_HASH, PH_LC:             pend_kind = KIND_COMMENT;
                PH_BLK, PH_BLK_BAR, PH_STR: pend_kind = KIND_UNDEF;
                PH_STR_Q:                   pend_kind = KIND_STRING;
                PH_COLON:                   pend_kind = KIND_COLON;
                default:                    pend_kind = KIND_UNDEF;
            endcase
            phase_next    = PH_IDLE;
            line_next     = LINE_ONE;
            tok_line_next = LINE_ONE;
            pos_next      = '0;
            tok_pos_next  = '0;
            tok_len_next  = '0;
            cand_next     = '0;
        end else if (fire) begin
            pos_next = pos_reg + POSITION_BITS'(1);
            unique case (phase_reg)
                PH_ID: begin
                    if (is_letter(in_byte) || is_digit(in_byte)) begin
                        cand_next    = cand_upd;
                        tok_len_next = len_inc;
                        done         = 1'b1;
                    end else begin
                        pend_v     = 1'b1;
                        pend_kind  = id_kind;
                        phase_next = PH_IDLE;
                    end
                end
                PH_HASH, PH_LC: begin
                    if (phase_reg == PH_HASH && in_byte == CH_BAR) begin
                        tok_len_next = len_inc;
                        phase_next   = PH_BLK;
                        done         = 1'b1;
                    end else if (in_byte == CH_NL) begin
                        pend_v     = 1'b1;
                        pend_kind  = KIND_COMMENT;
                        phase_next = PH_IDLE;
                    end else begin
                        tok_len_next = len_inc;
                        phase_next   = PH_LC;
                        done         = 1'b1;
                    end
                end
                PH_BLK: begin
                    tok_len_next = len_inc;
                    done         = 1'b1;
                    if (in_byte == CH_BAR) begin
                        phase_next = PH_BLK_BAR;
                    end else if (in_byte == CH_NL) begin
                        line_next = line_inc;
                    end
                end
                PH_BLK_BAR: begin
                    tok_len_next = len_inc;
                    done         = 1'b1;
                    if (in_byte == CH_HASH) begin
                        pend_v     = 1'b1;
                        pend_kind  = KIND_COMMENT;
                        pend_len   = len_inc;
                        phase_next = PH_IDLE;
                    end else if (in_byte != CH_BAR) begin
                        if (in_byte == CH_NL) begin
                            line_next = line_inc;
                        end
                        phase_next = PH_BLK;
                    end
                end
                PH_STR: begin
                    tok_len_next = len_inc;
                    done         = 1'b1;
                    if (in_byte == CH_QUOTE) begin
                        phase_next = PH_STR_Q;
                    end else if (in_byte == CH_NL) begin
                        line_next = line_inc;
                    end
                end
                PH_STR_Q: begin
                    if (in_byte == CH_QUOTE) begin
                        tok_len_next = len_inc;
                        phase_next   = PH_STR;
                        done         = 1'b1;
                    end else begin
                        pend_v     = 1'b1;
                        pend_kind  = KIND_STRING;
                        phase_next = PH_IDLE;
                    end
                end
                PH_COLON: begin
                    pend_v     = 1'b1;
                    phase_next = PH_IDLE;
                    if (in_byte == CH_DASH) begin
                        tok_len_next = len_inc;
                        pend_kind    = KIND_COLONDASH;
                        pend_len     = len_inc;
                        done         = 1'b1;
                    end else begin
                        pend_kind = KIND_COLON;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            // The byte was not absorbed by a pending token, so it starts over from idle.
            if (!done) begin
                if (is_letter(in_byte) || in_byte == CH_HASH || in_byte == CH_QUOTE
                        || in_byte == CH_COLON) begin
                    tok_line_next = line_reg;
                    tok_pos_next  = pos_reg;
                    tok_len_next  = LEN_ONE;
                end
                priority if (is_letter(in_byte)) begin
                    cand_next  = cand_first;
                    phase_next = PH_ID;
                end else if (in_byte == CH_HASH) begin
                    phase_next = PH_HASH;
                end else if (in_byte == CH_QUOTE) begin
                    phase_next = PH_STR;
                end else if (in_byte == CH_COLON) begin
                    phase_next = PH_COLON;
                end else if (in_byte == CH_NL) begin
                    line_next = line_inc;
                end else if (is_space(in_byte)) begin
                    idle_v = 1'b0;
                end else begin
                    idle_v = 1'b1;
                    unique case (in_byte)
                        CH_COMMA:  idle_kind = KIND_COMMA;
                        CH_PERIOD: idle_kind = KIND_PERIOD;
                        CH_QMARK:  idle_kind = KIND_QMARK;
                        CH_LPAREN: idle_kind = KIND_LPAREN;
                        CH_RPAREN: idle_kind = KIND_RPAREN;
                        CH_STAR:   idle_kind = KIND_MUL;
                        CH_PLUS:   idle_kind = KIND_ADD;
                        default:   idle_kind = KIND_UNDEF;
                    endcase
                end
            end
        end
    end

    always_comb begin
        second_v = fire && (mode || idle_v);
        pend_tok = {pend_kind, tok_line_reg, tok_pos_reg, pend_len, 1'b0};
        if (mode) begin
            second_tok = {KIND_EOF, line_reg, pos_reg, LENGTH_BITS'(0), 1'b1};
        end else begin
            second_tok = {idle_kind, line_reg, pos_reg, LEN_ONE, 1'b1};
        end
        res_cnt = {1'b0, fire && pend_v} + {1'b0, second_v};
        res1    = second_tok;
        if (fire && pend_v) begin
            res0 = {pend_tok[TOK_W-1:1], !second_v};
        end else begin
            res0 = second_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            line_reg     <= LINE_ONE;
            tok_line_reg <= LINE_ONE;
            pos_reg      <= '0;
            tok_pos_reg  <= '0;
            tok_len_reg  <= '0;
            cand_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            line_reg     <= line_next;
            tok_line_reg <= tok_line_next;
            pos_reg      <= pos_next;
            tok_pos_reg  <= tok_pos_next;
            tok_len_reg  <= tok_len_next;
            cand_reg     <= cand_next;
        end
    end

    // An end-of-input transfer always yields a token and returns the lexer to its start state.
    a_eof_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mode |-> res_cnt != 2'd0)
        else $error("end of input produced no token");

    a_eof_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mode |=> phase_reg == PH_IDLE && pos_reg == '0 && line_reg == LINE_ONE)
        else $error("lexer did not restart after end of input");

    a_open_token_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> tok_len_reg != '0)
        else $error("open token has zero length");

endmodule

// ===== rtl/dlex_outbuf.sv =====
// Two-entry result register that takes one or two tokens per input transfer.
module dlex_outbuf #(
    parameter int TOK_W = 70
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  logic [TOK_W-1:0] push0,
    input  logic [TOK_W-1:0] push1,
    input  logic             m_ready,
    output logic             s_ready,
    output logic             m_valid,
    output logic [TOK_W-1:0] m_tok
);

    logic [1:0]       count_reg, count_next;
    logic [TOK_W-1:0] slot0_reg, slot0_next;
    logic [TOK_W-1:0] slot1_reg, slot1_next;
    logic             pop;
    logic             push;

    assign m_valid = (count_reg != 2'd0);
    assign m_tok   = slot0_reg;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign push    = (push_cnt != 2'd0);

    always_comb begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push) begin
            count_next = push_cnt;
            slot0_next = push0;
            slot1_next = push1;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg == 2'd0 || pop)
        else $error("tokens pushed into a full result register");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result count out of range");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> slot1_reg[0] && !slot0_reg[0])
        else $error("token pair has wrong last-of-run marks");

endmodule

// ===== rtl/datalog_lexer_top.sv =====
// Latency: a token appears on the m_ side in the cycle after the input transfer that completes it.
// Throughput: one byte per cycle while m_ready is high; a byte that completes two tokens holds s_ready low
// until the two-entry result register has passed the first of them on to the m_ side.
// The lexer state is updated in the same cycle as the input transfer, in a single pass.
// Reset (aresetn low, synchronous): line 1, position 0, no open token, result register empty.
module datalog_lexer_top import dlex_pkg::*; #(
    parameter int LINE_BITS     = LINE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [7:0]               s_in_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KIND_W-1:0]        m_token_kind,
    output logic [LINE_BITS-1:0]     m_line_number,
    output logic [POSITION_BITS-1:0] m_start_position,
    output logic [LENGTH_BITS-1:0]   m_lexeme_length,
    output logic                     m_last_of_run
);

    localparam int TOK_W = KIND_W + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1;

    logic             fire;
    logic [1:0]       res_cnt;
    logic [TOK_W-1:0] res0;
    logic [TOK_W-1:0] res1;
    logic [TOK_W-1:0] m_tok;

    assign fire = s_valid && s_ready;

    dlex_core #(
        .LINE_BITS     (LINE_BITS),
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS),
        .TOK_W         (TOK_W)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .mode    (s_mode),
        .in_byte (s_in_byte),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    dlex_outbuf #(
        .TOK_W (TOK_W)
    ) u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (res_cnt),
        .push0    (res0),
        .push1    (res1),
        .m_ready  (m_ready),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_tok    (m_tok)
    );

    assign {m_token_kind, m_line_number, m_start_position, m_lexeme_length, m_last_of_run} = m_tok;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the streaming Datalog lexer, with a token predictor and scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlex_pkg::*;

    localparam int          DIRECTED_ROWS = 29;
    localparam int          RANDOM_ITEMS  = 1300;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          HOLD_CYCLES   = 300;

    localparam logic [3:0][55:0] KW_SPELL =
        {"Queries", {"Rules", 16'h0}, {"Facts", 16'h0}, "Schemes"};
    localparam logic [3:0][3:0]  KW_SIZE  = {4'd7, 4'd5, 4'd5, 4'd7};
    localparam logic [6:0][7:0]  PUNCT_CH =
        {CH_COMMA, CH_PERIOD, CH_QMARK, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS};
    localparam logic [5:0][7:0]  BLANK_CH = {CH_SPACE, 8'h09, CH_NL, 8'h0B, 8'h0C, 8'h0D};

    typedef struct packed {
        tok_kind_t                    kind;
        logic [LINE_BITS_DEF-1:0]     line;
        logic [POSITION_BITS_DEF-1:0] pos;
        logic [LENGTH_BITS_DEF-1:0]   len;
        logic                         last;
    } token_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] chr;
        logic       known;
        token_t     want;
    } dir_row_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic                         s_mode    = 1'b0;
    logic [7:0]                   s_in_byte = 8'h00;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    logic [KIND_W-1:0]            m_token_kind;
    logic [LINE_BITS_DEF-1:0]     m_line_number;
    logic [POSITION_BITS_DEF-1:0] m_start_position;
    logic [LENGTH_BITS_DEF-1:0]   m_lexeme_length;
    logic                         m_last_of_run;

    token_t      tokens_due [$];
    token_t      step_out [$];
    dir_row_t    dir_tab [DIRECTED_ROWS];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int unsigned cycle_count = 0;
    logic        tx_calm     = 1'b0;
    logic        rx_calm     = 1'b0;
    logic        hold_req    = 1'b0;

    phase_t                       lx_phase;
    logic [LINE_BITS_DEF-1:0]     lx_line;
    logic [LINE_BITS_DEF-1:0]     lx_tok_line;
    logic [POSITION_BITS_DEF-1:0] lx_pos;
    logic [POSITION_BITS_DEF-1:0] lx_tok_pos;
    logic [LENGTH_BITS_DEF-1:0]   lx_len;
    logic [3:0]                   lx_cand;

    datalog_lexer_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_line_number    (m_line_number),
        .m_start_position (m_start_position),
        .m_lexeme_length  (m_lexeme_length),
        .m_last_of_run    (m_last_of_run)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] kw_byte(int k, int i);
        if (i >= 7) return 8'h00;
        return KW_SPELL[k][55 - 8 * i -: 8];
    endfunction

    function automatic token_t mk_tok(tok_kind_t k, logic [LINE_BITS_DEF-1:0] ln,
                                      logic [POSITION_BITS_DEF-1:0] p,
                                      logic [LENGTH_BITS_DEF-1:0] l);
        token_t t;
        t.kind = k;
        t.line = ln;
        t.pos  = p;
        t.len  = l;
        t.last = 1'b0;
        return t;
    endfunction

    function void lexer_restart();
        lx_phase    = PH_IDLE;
        lx_line     = 1;
        lx_tok_line = 1;
        lx_pos      = '0;
        lx_tok_pos  = '0;
        lx_len      = '0;
        lx_cand     = '0;
    endfunction

    function void bump_line();
        if (lx_line != '1) lx_line = lx_line + 1'b1;
    endfunction

    function void bump_len();
        if (lx_len != '1) lx_len = lx_len + 1'b1;
    endfunction

    function void put_pending(tok_kind_t k);
        step_out = {step_out, mk_tok(k, lx_tok_line, lx_tok_pos, lx_len)};
        lx_phase = PH_IDLE;
    endfunction

    function void open_token(logic [POSITION_BITS_DEF-1:0] p, phase_t ph);
        lx_tok_line = lx_line;
        lx_tok_pos  = p;
        lx_len      = 1;
        lx_phase    = ph;
    endfunction

    function tok_kind_t ident_kind();
        for (int k = 0; k < 4; k++)
            if (lx_cand[k] && lx_len == KW_SIZE[k]) return tok_kind_t'(KIND_SCHEMES + k);
        return KIND_ID;
    endfunction

    function void lex_from_idle(logic [7:0] c, logic [POSITION_BITS_DEF-1:0] p);
        tok_kind_t k;
        if (alpha(c)) begin
            lx_cand = '0;
            for (int i = 0; i < 4; i++)
                if (kw_byte(i, 0) == c) lx_cand[i] = 1'b1;
            open_token(p, PH_ID);
        end else if (c == CH_HASH) begin
            open_token(p, PH_HASH);
        end else if (c == CH_QUOTE) begin
            open_token(p, PH_STR);
        end else if (c == CH_COLON) begin
            open_token(p, PH_COLON);
        end else if (c == CH_NL) begin
            bump_line();
        end else if (!blank(c)) begin
            case (c)
                CH_COMMA:  k = KIND_COMMA;
                CH_PERIOD: k = KIND_PERIOD;
                CH_QMARK:  k = KIND_QMARK;
                CH_LPAREN: k = KIND_LPAREN;
                CH_RPAREN: k = KIND_RPAREN;
                CH_STAR:   k = KIND_MUL;
                CH_PLUS:   k = KIND_ADD;
                default:   k = KIND_UNDEF;
            endcase
            step_out = {step_out, mk_tok(k, lx_line, p, 1)};
        end
    endfunction

    // Advances the lexer by one input transfer and leaves the tokens it causes in step_out.
    function void lex_step(logic mode, logic [7:0] c);
        logic [POSITION_BITS_DEF-1:0] p;
        logic                         consumed;
        logic [3:0]                   keep;
        token_t                       t;
        p        = lx_pos;
        consumed = 1'b0;
        step_out.delete();
        if (mode) begin
            case (lx_phase)
                PH_ID:                      put_pending(ident_kind());
                PH_HASH, PH_LC:             put_pending(KIND_COMMENT);
                PH_BLK, PH_BLK_BAR, PH_STR: put_pending(KIND_UNDEF);
                PH_STR_Q:                   put_pending(KIND_STRING);
                PH_COLON:                   put_pending(KIND_COLON);
                default: ;
            endcase
            step_out = {step_out, mk_tok(KIND_EOF, lx_line, lx_pos, 0)};
            lexer_restart();
        end else begin
            lx_pos = lx_pos + 1'b1;
            case (lx_phase)
                PH_ID: begin
                    if (alpha(c) || numeral(c)) begin
                        keep = lx_cand;
                        for (int k = 0; k < 4; k++)
                            if (lx_len >= KW_SIZE[k] || kw_byte(k, lx_len) != c) keep[k] = 1'b0;
                        lx_cand = keep;
                        bump_len();
                        consumed = 1'b1;
                    end else begin
                        put_pending(ident_kind());
                    end
                end
                PH_HASH: begin
                    if (c == CH_BAR) begin
                        bump_len();
                        lx_phase = PH_BLK;
                        consumed = 1'b1;
                    end else if (c == CH_NL) begin
                        put_pending(KIND_COMMENT);
                    end else begin
                        lx_phase = PH_LC;
                        bump_len();
                        consumed = 1'b1;
                    end
                end
                PH_LC: begin
                    if (c == CH_NL) begin
                        put_pending(KIND_COMMENT);
                    end else begin
                        bump_len();
                        consumed = 1'b1;
                    end
                end
                PH_BLK: begin
                    bump_len();
                    if (c == CH_BAR) lx_phase = PH_BLK_BAR;
                    else if (c == CH_NL) bump_line();
                    consumed = 1'b1;
                end
                PH_BLK_BAR: begin
                    bump_len();
                    if (c == CH_HASH) begin
                        put_pending(KIND_COMMENT);
                    end else if (c != CH_BAR) begin
                        if (c == CH_NL) bump_line();
                        lx_phase = PH_BLK;
                    end
                    consumed = 1'b1;
                end
                PH_STR: begin
                    bump_len();
                    if (c == CH_QUOTE) lx_phase = PH_STR_Q;
                    else if (c == CH_NL) bump_line();
                    consumed = 1'b1;
                end
                PH_STR_Q: begin
                    if (c == CH_QUOTE) begin
                        bump_len();
                        lx_phase = PH_STR;
                        consumed = 1'b1;
                    end else begin
                        put_pending(KIND_STRING);
                    end
                end
                PH_COLON: begin
                    if (c == CH_DASH) begin
                        bump_len();
                        put_pending(KIND_COLONDASH);
                        consumed = 1'b1;
                    end else begin
                        put_pending(KIND_COLON);
                    end
                end
                default: lx_phase = PH_IDLE;
            endcase
            if (!consumed) lex_from_idle(c, p);
        end
        if (step_out.size() > 0) begin
            t = step_out[step_out.size() - 1];
            t.last = 1'b1;
            step_out[step_out.size() - 1] = t;
        end
    endfunction

    function automatic dir_row_t row_pred(logic mode, logic [7:0] chr);
        dir_row_t r;
        r       = '0;
        r.mode  = mode;
        r.chr   = chr;
        return r;
    endfunction

    function automatic dir_row_t row_known(logic mode, logic [7:0] chr, tok_kind_t k,
                                           int ln, int p, int l);
        dir_row_t r;
        r       = row_pred(mode, chr);
        r.known = 1'b1;
        r.want  = mk_tok(k, LINE_BITS_DEF'(ln), POSITION_BITS_DEF'(p), LENGTH_BITS_DEF'(l));
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'($urandom_range(8'h41, 8'h5A));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] filler();
        case ($urandom_range(0, 10))
            0, 1, 2, 3: return rand_letter();
            4:          return rand_digit();
            5:          return CH_SPACE;
            6:          return CH_NL;
            7:          return CH_QUOTE;
            8:          return CH_BAR;
            9:          return CH_HASH;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_item(input logic mode, input logic [7:0] chr, input logic known,
                             input token_t want);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_in_byte <= chr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        lex_step(mode, chr);
        if (known) tokens_due = {tokens_due, want};
        else foreach (step_out[i]) tokens_due = {tokens_due, step_out[i]};
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] chr);
        push_item(1'b0, chr, 1'b0, '0);
    endtask

    task automatic send_eof();
        push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Sends one mostly well-formed token; open_end reports a string or comment left open.
    task automatic send_token(output logic open_end);
        int         n;
        int         k;
        int         how;
        int         flip;
        logic [7:0] b;
        open_end = 1'b0;
        case ($urandom_range(0, 13))
            0, 1: send_byte(PUNCT_CH[$urandom_range(0, 6)]);
            2, 3: begin
                send_byte(rand_letter());
                n = $urandom_range(0, 7);
                repeat (n) send_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
            end
            4, 5: begin
                k   = $urandom_range(0, 3);
                n   = KW_SIZE[k];
                how = $urandom_range(0, 3);
                if (how == 1) n = $urandom_range(1, n - 1);
                flip = $urandom_range(1, n - 1);
                for (int i = 0; i < n; i++)
                    send_byte((how == 3 && i == flip) ? kw_byte(k, i) ^ 8'h20 : kw_byte(k, i));
                if (how == 2) send_byte($urandom_range(0, 1) ? rand_digit() : rand_letter());
            end
            6: begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    b = filler();
                    send_byte(b);
                    if (b == CH_QUOTE) send_byte(CH_QUOTE);
                end
                if ($urandom_range(0, 5) == 0) open_end = 1'b1;
                else send_byte(CH_QUOTE);
            end
            7: begin
                send_byte(CH_HASH);
                send_byte(CH_BAR);
                n = $urandom_range(0, 8);
                repeat (n) send_byte(filler());
                if ($urandom_range(0, 5) == 0) begin
                    open_end = 1'b1;
                end else begin
                    send_byte(CH_BAR);
                    send_byte(CH_HASH);
                end
            end
            8: begin
                send_byte(CH_HASH);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    b = filler();
                    send_byte((b == CH_NL || b == CH_BAR) ? CH_SPACE : b);
                end
                if ($urandom_range(0, 5) == 0) open_end = 1'b1;
                else send_byte(CH_NL);
            end
            9: begin
                send_byte(CH_COLON);
                if ($urandom_range(0, 1)) send_byte(CH_DASH);
            end
            10:      send_byte(8'($urandom_range(0, 255)));
            default: send_byte(BLANK_CH[$urandom_range(0, 5)]);
        endcase
        if (!open_end && $urandom_range(0, 1)) send_byte(BLANK_CH[$urandom_range(0, 5)]);
    endtask

    initial begin : result_check
        token_t got;
        token_t want;
        int     stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                for (int w = 0; w < stall; w++) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.kind = tok_kind_t'(m_token_kind);
            got.line = m_line_number;
            got.pos  = m_start_position;
            got.len  = m_lexeme_length;
            got.last = m_last_of_run;
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token, kind %0d line %0d position %0d length %0d",
                         $time, got.kind, got.line, got.pos, got.len);
                mismatches++;
            end else begin
                want = tokens_due.pop_front();
                cmp_field("token_kind", want.kind, got.kind);
                cmp_field("line_number", want.line, got.line);
                cmp_field("start_position", want.pos, got.pos);
                cmp_field("lexeme_length", want.len, got.len);
                cmp_field("last_of_run", want.last, got.last);
            end
        end
    end

    initial begin : stimulus
        int   ntok;
        int   stream_no;
        logic open_end;
        lexer_restart();
        dir_tab = '{
            row_known(1'b1, 8'h00, KIND_EOF, 1, 0, 0),
            row_known(1'b0, CH_COMMA, KIND_COMMA, 1, 0, 1),
            row_known(1'b0, CH_PERIOD, KIND_PERIOD, 1, 1, 1),
            row_known(1'b0, CH_QMARK, KIND_QMARK, 1, 2, 1),
            row_known(1'b0, CH_LPAREN, KIND_LPAREN, 1, 3, 1),
            row_known(1'b0, CH_RPAREN, KIND_RPAREN, 1, 4, 1),
            row_known(1'b0, CH_STAR, KIND_MUL, 1, 5, 1),
            row_known(1'b0, CH_PLUS, KIND_ADD, 1, 6, 1),
            row_known(1'b0, 8'hFF, KIND_UNDEF, 1, 7, 1),
            row_known(1'b0, 8'h00, KIND_UNDEF, 1, 8, 1),
            row_pred(1'b0, CH_COLON),
            row_known(1'b0, CH_DASH, KIND_COLONDASH, 1, 9, 2),
            row_pred(1'b0, CH_NL),
            row_pred(1'b0, "F"),
            row_pred(1'b0, "a"),
            row_pred(1'b0, "c"),
            row_pred(1'b0, "t"),
            row_pred(1'b0, "s"),
            row_pred(1'b0, CH_COLON),
            row_pred(1'b0, CH_QUOTE),
            row_pred(1'b0, CH_QUOTE),
            row_pred(1'b0, CH_QUOTE),
            row_pred(1'b0, CH_QUOTE),
            row_pred(1'b0, CH_HASH),
            row_pred(1'b0, CH_BAR),
            row_pred(1'b0, CH_BAR),
            row_pred(1'b0, CH_HASH),
            row_pred(1'b0, CH_HASH),
            row_pred(1'b1, 8'h5A)
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            push_item(dir_tab[i].mode, dir_tab[i].chr, dir_tab[i].known, dir_tab[i].want);

        stream_no = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            if (stream_no % 8 == 1) hold_req = 1'b1;
            ntok     = $urandom_range(1, 40);
            open_end = 1'b0;
            for (int t = 0; t < ntok && !open_end; t++) send_token(open_end);
            send_eof();
            stream_no++;
        end
        s_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
